@@ rtl/pfpo_pkg.sv @@
// shared types, constants and the cordic arctangent table for the flux position observer
package pfpo_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_STATOR_RESISTANCE = 3'd0;
  localparam logic [2:0] REG_D_INDUCTANCE      = 3'd1;
  localparam logic [2:0] REG_Q_INDUCTANCE      = 3'd2;
  localparam logic [2:0] REG_NOMINAL_CURRENT   = 3'd3;
  localparam logic [2:0] REG_NOMINAL_FREQUENCY = 3'd4;
  localparam logic [2:0] REG_SPEED_MAX         = 3'd5;
  localparam logic [2:0] REG_SPEED_MIN         = 3'd6;
  localparam logic [2:0] REG_SAMPLE_PERIOD     = 3'd7;

  // register reset values
  localparam logic [30:0] RST_NOMINAL_CURRENT   = 31'd1048576;
  localparam logic [30:0] RST_NOMINAL_FREQUENCY = 31'd838860800;
  localparam logic [30:0] RST_SPEED_MAX         = 31'd16777216;
  localparam logic [30:0] RST_SPEED_MIN         = 31'd167772;
  localparam logic [30:0] RST_SAMPLE_PERIOD     = 31'd1677;

  // fixed-point constants
  localparam logic signed [31:0] K_SQRT2_Q20   = 32'sd1482910;
  localparam logic signed [31:0] K_SQRT3_Q20   = 32'sd1816186;
  localparam logic signed [31:0] K_TWO_PI_Q24  = 32'sd105414357;
  localparam logic signed [31:0] K_ONE_Q19     = 32'sd524288;
  localparam logic [23:0]        K_EIGHTH7_Q24 = 24'd14680064;
  localparam logic signed [31:0] GAIN_INV_Q24  = 32'sd10188014;
  localparam logic signed [40:0] GAIN_INV_Q30  = 41'sd652032874;
  localparam logic signed [40:0] ONE_Q24       = 41'sd16777216;

  // ceil(2^72 / K_SQRT3_Q20) split at bit 31: exact floor(udc * 2^20 / K_SQRT3_Q20)
  // for any 31-bit udc as (udc * recip) >> 52
  localparam logic signed [31:0] K_INV_SQRT3_LO = 32'sd1882906705;
  localparam logic signed [31:0] K_INV_SQRT3_HI = 32'sd1210791;

  // divider: dividend magnitude shifted by up to 24 bits
  localparam int DIV_W     = 56;
  localparam int DIV_CNT_W = 6;

  // cordic datapath width: 32-bit input scaled by 64 plus growth
  localparam int COR_W = 41;

  typedef struct packed {
    logic start;
    logic shift24;
  } div_req_t;

  typedef struct packed {
    logic start;
    logic vect;
  } cor_req_t;

  // arctangent of 2^-i in q32 turns
  function automatic logic [31:0] atan_turn(logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/pfpo_div.sv @@
// bit-serial signed divider: (a * 2^n) / b, truncated toward zero and saturated
module pfpo_div import pfpo_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  div_req_t            req,
  input  logic signed [31:0]  dividend,
  input  logic signed [31:0]  divisor,
  output logic                done,
  output logic signed [31:0]  quotient
);

  logic [DIV_W-1:0]     work;
  logic [31:0]          rem;
  logic [31:0]          dvs;
  logic                 neg;
  logic                 bz;
  logic                 a_pos;
  logic                 a_neg;
  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          mag_a;
  logic [31:0]          mag_b;
  logic [31:0]          trial;
  logic                 ge;

  // operand magnitudes
  assign mag_a = dividend[31] ? 32'(-dividend) : 32'(dividend);
  assign mag_b = divisor[31] ? 32'(-divisor) : 32'(divisor);

  // one quotient bit per cycle
  assign trial = {rem[30:0], work[DIV_W-1]};
  assign ge    = (trial >= dvs);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= '0;
        if (divisor == 32'sd0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      work  <= req.shift24 ? {mag_a, 24'b0} : {4'b0, mag_a, 20'b0};
      rem   <= '0;
      dvs   <= mag_b;
      neg   <= dividend[31] ^ divisor[31];
      bz    <= (divisor == 32'sd0);
      a_pos <= !dividend[31] && (dividend != 32'sd0);
      a_neg <= dividend[31];
    end else if (busy) begin
      rem  <= ge ? (trial - dvs) : trial;
      work <= {work[DIV_W-2:0], ge};
    end
  end

  // sign and saturation of the result
  always_comb begin
    if (bz) begin
      if (a_pos) quotient = 32'sh7FFFFFFF;
      else if (a_neg) quotient = 32'sh80000000;
      else quotient = 32'sd0;
    end else if (!neg) begin
      if (|work[DIV_W-1:31]) quotient = 32'sh7FFFFFFF;
      else quotient = $signed(work[31:0]);
    end else begin
      if (|work[DIV_W-1:32] || (work[31] && |work[30:0])) quotient = 32'sh80000000;
      else quotient = $signed(32'(-work[31:0]));
    end
  end

endmodule

@@ rtl/pfpo_cordic.sv @@
// iterative cordic: vectoring (angle, raw magnitude) and rotation (cos, sin)
module pfpo_cordic import pfpo_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cor_req_t                 req,
  input  logic signed [31:0]       x_in,
  input  logic signed [31:0]       y_in,
  input  logic [23:0]              ang_in,
  output logic                     done,
  output logic [23:0]              ang_out,
  output logic signed [COR_W-1:0]  x_out,
  output logic signed [31:0]       cos_out,
  output logic signed [31:0]       sin_out
);

  localparam int CNT_W = $clog2(STEPS);

  logic signed [COR_W-1:0] x;
  logic signed [COR_W-1:0] y;
  logic [31:0]             z;
  logic                    vect;
  logic                    neg;
  logic                    zero;
  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic signed [COR_W-1:0] xs;
  logic signed [COR_W-1:0] ys;
  logic [31:0]             zr;
  logic [31:0]             atan;
  logic signed [COR_W-1:0] dx;
  logic signed [COR_W-1:0] dy;
  logic                    up;
  logic [31:0]             z_rnd;

  // undo the scale of 64, round to q24, flip and clamp to +-1.0
  function automatic logic signed [31:0] to_q24(logic signed [COR_W-1:0] v, logic flip);
    logic signed [COR_W-1:0] r;
    r = (v + COR_W'(32)) >>> 6;
    if (flip) r = -r;
    if (r > ONE_Q24) r = ONE_Q24;
    if (r < -ONE_Q24) r = -ONE_Q24;
    return r[31:0];
  endfunction

  // start values
  assign xs = $signed({{(COR_W-38){x_in[31]}}, x_in, 6'b0});
  assign ys = $signed({{(COR_W-38){y_in[31]}}, y_in, 6'b0});
  assign zr = {ang_in, 8'b0};

  // one micro-rotation
  assign atan = atan_turn(5'(cnt));
  assign dx   = x >>> cnt;
  assign dy   = y >>> cnt;
  assign up   = vect ? (!y[COR_W-1] && (y != '0)) : z[31];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      vect <= req.vect;
      if (req.vect) begin
        zero <= (x_in == 32'sd0) && (y_in == 32'sd0);
        neg  <= 1'b0;
        if (x_in[31]) begin
          x <= -xs;
          y <= -ys;
          z <= 32'h80000000;
        end else begin
          x <= xs;
          y <= ys;
          z <= 32'h0;
        end
      end else begin
        zero <= 1'b0;
        x    <= GAIN_INV_Q30;
        y    <= '0;
        if ((zr - 32'h40000000) < 32'h80000000) begin
          z   <= zr - 32'h80000000;
          neg <= 1'b1;
        end else begin
          z   <= zr;
          neg <= 1'b0;
        end
      end
    end else if (busy) begin
      if (up) begin
        x <= x + dy;
        y <= y - dx;
        z <= z + atan;
      end else begin
        x <= x - dy;
        y <= y + dx;
        z <= z - atan;
      end
    end
  end

  // results
  assign z_rnd   = z + 32'd128;
  assign ang_out = zero ? 24'd0 : z_rnd[31:8];
  assign x_out   = x;
  assign cos_out = to_q24(x, neg);
  assign sin_out = to_q24(y, neg);

endmodule

@@ rtl/pmsm_flux_position_observer_top.sv @@
// Flux-linkage rotor position observer for a PMSM. Each accepted sample runs
// through a step sequencer that drives one 32x32 multiplier, a bit-serial
// divider (one quotient bit per cycle, 56 bits) and an iterative CORDIC
// (CORDIC_STEPS iterations). The voltage base is formed by a two-step
// reciprocal multiplication, so the divider serves five divisions. When the
// filter time constant is unchanged the two coefficient divisions are
// skipped. The divider takes the largest share of a sample's time. The
// sample port stalls while a sample is in work; a finished result waits in
// an output register while the next sample is taken.
module pmsm_flux_position_observer_top import pfpo_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [31:0] volt_alpha,
  input  logic signed [31:0] volt_beta,
  input  logic signed [31:0] curr_alpha,
  input  logic signed [31:0] curr_beta,
  input  logic [30:0]        bus_voltage,
  input  logic signed [31:0] speed,
  input  logic               hold_reset,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [23:0]        angle,
  output logic signed [31:0] flux_comp_alpha,
  output logic signed [31:0] flux_comp_beta,
  output logic signed [31:0] flux_curr_alpha,
  output logic signed [31:0] flux_curr_beta,
  output logic signed [31:0] time_constant
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_MULWB = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    K_MUL,
    K_DIV,
    K_COR
  } kind_t;

  // sequencer steps
  localparam logic [5:0] P_BASEV  = 6'd0;
  localparam logic [5:0] P_BASEV1 = 6'd1;
  localparam logic [5:0] P_INOMPK = 6'd2;
  localparam logic [5:0] P_RS0    = 6'd3;
  localparam logic [5:0] P_RS1    = 6'd4;
  localparam logic [5:0] P_TF0    = 6'd5;
  localparam logic [5:0] P_TF1    = 6'd6;
  localparam logic [5:0] P_TF2    = 6'd7;
  localparam logic [5:0] P_CI     = 6'd8;
  localparam logic [5:0] P_CF     = 6'd9;
  localparam logic [5:0] P_EA     = 6'd10;
  localparam logic [5:0] P_EB     = 6'd11;
  localparam logic [5:0] P_FA0    = 6'd12;
  localparam logic [5:0] P_FA1    = 6'd13;
  localparam logic [5:0] P_FA2    = 6'd14;
  localparam logic [5:0] P_FB0    = 6'd15;
  localparam logic [5:0] P_FB1    = 6'd16;
  localparam logic [5:0] P_FB2    = 6'd17;
  localparam logic [5:0] P_V1     = 6'd18;
  localparam logic [5:0] P_MAG0   = 6'd19;
  localparam logic [5:0] P_MAG1   = 6'd20;
  localparam logic [5:0] P_R1     = 6'd21;
  localparam logic [5:0] P_FCA    = 6'd22;
  localparam logic [5:0] P_FCB    = 6'd23;
  localparam logic [5:0] P_RATIO  = 6'd24;
  localparam logic [5:0] P_LS     = 6'd25;
  localparam logic [5:0] P_LSD    = 6'd26;
  localparam logic [5:0] P_R2     = 6'd27;
  localparam logic [5:0] P_LSA    = 6'd28;
  localparam logic [5:0] P_LM     = 6'd29;
  localparam logic [5:0] P_FA2A   = 6'd30;
  localparam logic [5:0] P_FA2B   = 6'd31;
  localparam logic [5:0] P_FB2A   = 6'd32;
  localparam logic [5:0] P_FB2B   = 6'd33;
  localparam logic [5:0] P_V2     = 6'd34;

  state_t state;
  logic [5:0] pc;
  kind_t kind;

  // configuration registers
  logic [30:0] stator_resistance;
  logic [30:0] d_inductance;
  logic [30:0] q_inductance;
  logic [30:0] nominal_current;
  logic [30:0] nominal_frequency;
  logic [30:0] speed_max;
  logic [30:0] speed_min;
  logic [30:0] sample_period;

  // sample registers
  logic signed [31:0] ua;
  logic signed [31:0] ub;
  logic signed [31:0] ia;
  logic signed [31:0] ib;
  logic [30:0]        udc;
  logic signed [31:0] w;
  logic               hold;

  // filter state
  logic signed [31:0] filt_flux_alpha;
  logic signed [31:0] filt_flux_beta;
  logic signed [31:0] last_time_constant;
  logic signed [31:0] coef_input;
  logic signed [31:0] coef_feedback;
  logic [23:0]        angle_state;

  // working registers
  logic signed [31:0] base_v;
  logic signed [31:0] inom_pk;
  logic signed [31:0] tmp;
  logic signed [31:0] rs_pu;
  logic signed [31:0] tf;
  logic signed [31:0] ea;
  logic signed [31:0] eb;
  logic [23:0]        th;
  logic signed [COR_W-1:0] cx;
  logic [43:0]        plo;
  logic signed [31:0] mag;
  logic signed [31:0] c;
  logic signed [31:0] s;
  logic signed [31:0] fca;
  logic signed [31:0] fcb;
  logic signed [31:0] ratio;
  logic signed [31:0] ls;
  logic signed [31:0] lsd;
  logic signed [31:0] lsa;
  logic signed [31:0] lsb;
  logic signed [31:0] lm;
  logic signed [31:0] fa2;
  logic signed [31:0] fb2;
  logic signed [63:0] prod;

  // unit interfaces
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] div_a;
  logic signed [31:0] div_b;
  logic               div_sh24;
  logic signed [31:0] cor_x;
  logic signed [31:0] cor_y;
  logic [23:0]        cor_ang;
  div_req_t           div_req;
  cor_req_t           cor_req;
  logic               div_done;
  logic signed [31:0] div_q;
  logic               cor_done;
  logic [23:0]        cor_ang_out;
  logic signed [COR_W-1:0] cor_x_out;
  logic signed [31:0] cor_cos;
  logic signed [31:0] cor_sin;

  // derived values
  logic               accept;
  logic               skip;
  logic               unit_done;
  logic               wb;
  logic               load_out;
  logic signed [31:0] sh20;
  logic signed [31:0] sh24;
  logic [31:0]        aw;
  logic [30:0]        ws;
  logic signed [31:0] den;
  logic [31:0]        dq_sum;
  logic [32:0]        dq_diff;
  logic signed [65:0] mag_sum;
  logic signed [35:0] mag_sh;
  logic signed [31:0] mag_clamp;
  logic [52:0]        bv_sum;

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;

  // scaled products of the shared multiplier
  assign sh20 = prod[51:20];
  assign sh24 = prod[55:24];

  // speed magnitude clamp
  assign aw = w[31] ? 32'(-w) : 32'(w);
  always_comb begin
    if (aw > {1'b0, speed_max}) ws = speed_max;
    else if (aw < {1'b0, speed_min}) ws = speed_min;
    else ws = aw[30:0];
  end

  assign den     = tf + $signed({1'b0, sample_period});
  assign dq_sum  = {1'b0, d_inductance} + {1'b0, q_inductance};
  assign dq_diff = {2'b0, d_inductance} - {2'b0, q_inductance};

  // voltage base: high partial product plus the upper bits of the low one
  assign bv_sum = prod[52:0] + {21'b0, tmp};

  // magnitude gain correction from two partial products
  assign mag_sum = $signed({prod[45:0], 20'b0}) + $signed({22'b0, plo});
  assign mag_sh  = mag_sum[65:30];
  always_comb begin
    if (mag_sh[35]) mag_clamp = 32'sd0;
    else if (|mag_sh[34:31]) mag_clamp = 32'sh7FFFFFFF;
    else mag_clamp = mag_sh[31:0];
  end

  // step decode
  always_comb begin
    case (pc)
      P_RS1, P_TF2, P_CI, P_CF, P_RATIO: kind = K_DIV;
      P_V1, P_R1, P_R2, P_V2:            kind = K_COR;
      default:                           kind = K_MUL;
    endcase
  end

  assign skip = ((pc == P_CI) && (tf == last_time_constant)) ||
                (((pc == P_EA) || (pc == P_V2)) && hold);
  assign unit_done = (kind == K_DIV) ? div_done : cor_done;
  assign wb        = (state == ST_MULWB) || ((state == ST_WAIT) && unit_done);
  assign load_out  = (state == ST_DONE) && (!result_valid || !result_stall);

  // multiplier operands
  always_comb begin
    mul_a = ia;
    mul_b = rs_pu;
    case (pc)
      P_BASEV:  begin mul_a = $signed({1'b0, udc}); mul_b = K_INV_SQRT3_LO; end
      P_BASEV1: begin mul_a = $signed({1'b0, udc}); mul_b = K_INV_SQRT3_HI; end
      P_INOMPK: begin mul_a = $signed({1'b0, nominal_current}); mul_b = K_SQRT2_Q20; end
      P_RS0:    begin mul_a = inom_pk; mul_b = $signed({2'b0, stator_resistance[30:1]}); end
      P_TF0:    begin mul_a = $signed({1'b0, ws}); mul_b = $signed({2'b0, nominal_frequency[30:1]}); end
      P_TF1:    begin mul_a = tmp; mul_b = K_TWO_PI_Q24; end
      P_EA:     begin mul_a = ia; mul_b = rs_pu; end
      P_EB:     begin mul_a = ib; mul_b = rs_pu; end
      P_FA0:    begin mul_a = ea; mul_b = tf; end
      P_FA1:    begin mul_a = tmp; mul_b = coef_input; end
      P_FA2:    begin mul_a = filt_flux_alpha; mul_b = coef_feedback; end
      P_FB0:    begin mul_a = eb; mul_b = tf; end
      P_FB1:    begin mul_a = tmp; mul_b = coef_input; end
      P_FB2:    begin mul_a = filt_flux_beta; mul_b = coef_feedback; end
      P_MAG0:   begin mul_a = $signed({12'b0, cx[19:0]}); mul_b = GAIN_INV_Q24; end
      P_MAG1:   begin mul_a = $signed({{11{cx[COR_W-1]}}, cx[COR_W-1:20]}); mul_b = GAIN_INV_Q24; end
      P_FCA:    begin mul_a = c; mul_b = mag; end
      P_FCB:    begin mul_a = s; mul_b = mag; end
      P_LS:     begin mul_a = $signed({1'b0, dq_sum[31:1]}); mul_b = ratio; end
      P_LSD:    begin mul_a = $signed(dq_diff[32:1]); mul_b = ratio; end
      P_LSA:    begin mul_a = lsd; mul_b = c; end
      P_LM:     begin mul_a = lsd; mul_b = s; end
      P_FA2A:   begin mul_a = ia; mul_b = lsa; end
      P_FA2B:   begin mul_a = ib; mul_b = lm; end
      P_FB2A:   begin mul_a = ib; mul_b = lsb; end
      P_FB2B:   begin mul_a = ia; mul_b = lm; end
      default:  begin mul_a = ia; mul_b = rs_pu; end
    endcase
  end

  // divider operands
  always_comb begin
    div_a    = tmp;
    div_b    = base_v;
    div_sh24 = 1'b0;
    case (pc)
      P_RS1:   begin div_a = tmp; div_b = base_v; end
      P_TF2:   begin div_a = K_ONE_Q19; div_b = tmp; div_sh24 = 1'b1; end
      P_CI:    begin div_a = $signed({1'b0, sample_period}); div_b = den; div_sh24 = 1'b1; end
      P_CF:    begin div_a = tf; div_b = den; div_sh24 = 1'b1; end
      P_RATIO: begin div_a = inom_pk; div_b = base_v; end
      default: begin div_a = tmp; div_b = base_v; end
    endcase
  end

  // cordic operands
  always_comb begin
    cor_x   = filt_flux_alpha;
    cor_y   = filt_flux_beta;
    cor_ang = th + K_EIGHTH7_Q24;
    case (pc)
      P_R2:    cor_ang = {angle_state[22:0], 1'b0};
      P_V2: begin
        cor_x = fca - fa2;
        cor_y = fcb - fb2;
      end
      default: cor_ang = th + K_EIGHTH7_Q24;
    endcase
  end

  assign div_req.start   = (state == ST_ISSUE) && (kind == K_DIV) && !skip;
  assign div_req.shift24 = div_sh24;
  assign cor_req.start   = (state == ST_ISSUE) && (kind == K_COR) && !skip;
  assign cor_req.vect    = (pc == P_V1) || (pc == P_V2);

  pfpo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  pfpo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .req     (cor_req),
    .x_in    (cor_x),
    .y_in    (cor_y),
    .ang_in  (cor_ang),
    .done    (cor_done),
    .ang_out (cor_ang_out),
    .x_out   (cor_x_out),
    .cos_out (cor_cos),
    .sin_out (cor_sin)
  );

  // sequencer, configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      pc                 <= P_BASEV;
      result_valid       <= 1'b0;
      stator_resistance  <= '0;
      d_inductance       <= '0;
      q_inductance       <= '0;
      nominal_current    <= RST_NOMINAL_CURRENT;
      nominal_frequency  <= RST_NOMINAL_FREQUENCY;
      speed_max          <= RST_SPEED_MAX;
      speed_min          <= RST_SPEED_MIN;
      sample_period      <= RST_SAMPLE_PERIOD;
      filt_flux_alpha    <= '0;
      filt_flux_beta     <= '0;
      last_time_constant <= '0;
      coef_input         <= '0;
      coef_feedback      <= '0;
      angle_state        <= '0;
    end else begin
      // configuration writes
      if (cfg_write) begin
        case (cfg_index)
          REG_STATOR_RESISTANCE: stator_resistance <= cfg_data;
          REG_D_INDUCTANCE:      d_inductance      <= cfg_data;
          REG_Q_INDUCTANCE:      q_inductance      <= cfg_data;
          REG_NOMINAL_CURRENT:   nominal_current   <= cfg_data;
          REG_NOMINAL_FREQUENCY: nominal_frequency <= cfg_data;
          REG_SPEED_MAX:         speed_max         <= cfg_data;
          REG_SPEED_MIN:         speed_min         <= cfg_data;
          REG_SAMPLE_PERIOD:     sample_period     <= cfg_data;
          default: ;
        endcase
      end

      // result handshake
      if (load_out) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;

      // step control
      case (state)
        ST_IDLE: begin
          if (accept) begin
            pc    <= P_BASEV;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if ((pc == P_CI) && (tf == last_time_constant)) begin
            pc <= P_EA;
          end else if ((pc == P_EA) && hold) begin
            filt_flux_alpha <= '0;
            filt_flux_beta  <= '0;
            pc              <= P_V1;
          end else if ((pc == P_V2) && hold) begin
            angle_state <= '0;
            state       <= ST_DONE;
          end else if (kind == K_MUL) begin
            state <= ST_MULWB;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_MULWB: begin
          pc    <= pc + 6'd1;
          state <= ST_ISSUE;
        end
        ST_WAIT: begin
          if (unit_done) begin
            if (pc == P_V2) begin
              state <= ST_DONE;
            end else begin
              pc    <= pc + 6'd1;
              state <= ST_ISSUE;
            end
          end
        end
        ST_DONE: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase

      // writeback to filter state
      if (wb) begin
        case (pc)
          P_CI:    coef_input <= div_q;
          P_CF: begin
            coef_feedback      <= div_q;
            last_time_constant <= tf;
          end
          P_FA2:   filt_flux_alpha <= tmp + sh24;
          P_FB2:   filt_flux_beta  <= tmp + sh24;
          P_V2:    angle_state     <= cor_ang_out;
          default: ;
        endcase
      end
    end
  end

  // sample capture, working registers and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ua   <= volt_alpha;
      ub   <= volt_beta;
      ia   <= curr_alpha;
      ib   <= curr_beta;
      udc  <= bus_voltage;
      w    <= speed;
      hold <= hold_reset;
    end

    // shared multiplier
    if (state == ST_ISSUE) prod <= mul_a * mul_b;

    if (wb) begin
      case (pc)
        P_BASEV:  tmp     <= prod[62:31];
        P_BASEV1: base_v  <= bv_sum[52:21];
        P_INOMPK: inom_pk <= sh20;
        P_RS0:    tmp     <= sh20;
        P_RS1:    rs_pu   <= {div_q[27:0], 4'b0};
        P_TF0:    tmp     <= sh24;
        P_TF1:    tmp     <= sh24;
        P_TF2:    tf      <= div_q;
        P_EA:     ea      <= ua - sh24;
        P_EB:     eb      <= ub - sh24;
        P_FA0:    tmp     <= sh24;
        P_FA1:    tmp     <= sh24;
        P_FB0:    tmp     <= sh24;
        P_FB1:    tmp     <= sh24;
        P_V1: begin
          th <= cor_ang_out;
          cx <= cor_x_out;
        end
        P_MAG0:   plo     <= prod[43:0];
        P_MAG1:   mag     <= mag_clamp;
        P_R1, P_R2: begin
          c <= cor_cos;
          s <= cor_sin;
        end
        P_FCA:    fca     <= sh24;
        P_FCB:    fcb     <= sh24;
        P_RATIO:  ratio   <= div_q;
        P_LS:     ls      <= {sh20[27:0], 4'b0};
        P_LSD:    lsd     <= {sh20[27:0], 4'b0};
        P_LSA: begin
          lsa <= ls + sh24;
          lsb <= ls - sh24;
        end
        P_LM:     lm      <= sh24;
        P_FA2A:   fa2     <= sh24;
        P_FA2B:   fa2     <= fa2 + sh24;
        P_FB2A:   fb2     <= sh24;
        P_FB2B:   fb2     <= fb2 + sh24;
        default: ;
      endcase
    end

    // result registers
    if (load_out) begin
      angle           <= angle_state;
      flux_comp_alpha <= fca;
      flux_comp_beta  <= fcb;
      flux_curr_alpha <= fa2;
      flux_curr_beta  <= fb2;
      time_constant   <= tf;
    end
  end

  // the multiplier writes back directly, only the divider and cordic are waited on
  a_wait_unit: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |-> kind != K_MUL)
    else $error("wait state entered on a multiplier step");

  // a finished transaction is held while the previous result is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && result_valid && result_stall |=> state == ST_DONE)
    else $error("result overwritten while stalled");

  // step counter stays within the program
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> pc <= P_V2)
    else $error("step counter out of range");

  // the divider and cordic never finish together
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(div_done && cor_done))
    else $error("divider and cordic finished together");

endmodule

@@ tb/tb_pmsm_flux_position_observer_top.sv @@
// testbench for the pmsm flux-linkage rotor position observer
`timescale 1ns / 1ps

module tb_pmsm_flux_position_observer_top;
  import pfpo_pkg::*;

  localparam int STEPS       = 24;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 700;
  localparam int PHASE_ITEMS = 135;

  typedef struct {
    logic signed [31:0] va, vb, ia, ib;
    logic [30:0]        udc;
    logic signed [31:0] spd;
    logic               hold;
  } sample_t;

  typedef struct {
    logic [23:0]        ang;
    logic signed [31:0] fca, fcb, fa, fb, tc;
  } estimate_t;

  // directed row: sample plus an optional typed-in angle; a typed row expects zero rotated flux
  typedef struct {
    sample_t s;
    bit      typed;
    logic [23:0] ang;
  } row_t;

  // arctangent of 2^-i in q32 turns
  localparam logic [31:0] ATAN_Q32 [30] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1};

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic sample_valid = 0;
  logic sample_stall;
  logic signed [31:0] volt_alpha = 0, volt_beta = 0, curr_alpha = 0, curr_beta = 0;
  logic [30:0] bus_voltage = 31'd1;
  logic signed [31:0] speed = 0;
  logic hold_reset = 0;
  logic result_valid;
  logic result_stall = 0;
  logic [23:0] angle;
  logic signed [31:0] flux_comp_alpha, flux_comp_beta, flux_curr_alpha, flux_curr_beta;
  logic signed [31:0] time_constant;

  pmsm_flux_position_observer_top #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .sample_valid, .sample_stall, .volt_alpha, .volt_beta, .curr_alpha, .curr_beta,
    .bus_voltage, .speed, .hold_reset,
    .result_valid, .result_stall, .angle, .flux_comp_alpha, .flux_comp_beta,
    .flux_curr_alpha, .flux_curr_beta, .time_constant
  );

  always #5 clk = ~clk;

  // observer registers and state as predicted
  logic [30:0] obs_reg [8];
  int obs_flux_a, obs_flux_b, obs_last_tc, obs_coef_in, obs_coef_fb;
  logic [23:0] obs_angle;

  estimate_t pending_estimates[$];
  int errors = 0;
  int samples_sent = 0;
  int estimates_seen = 0;
  int holds_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // fixed-point helpers
  function automatic int fx_mul(int a, int b, int n);
    longint p;
    p = longint'(a) * longint'(b);
    return int'(p >>> n);
  endfunction

  function automatic int fx_div(int a, int b, int n);
    longint q;
    if (b == 0) return a > 0 ? 32'sh7fffffff : (a < 0 ? 32'sh80000000 : 0);
    q = (longint'(a) <<< n) / longint'(b);
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return int'(q);
  endfunction

  function automatic int q20_to_q24(int v);
    return int'(longint'(v) * 16);
  endfunction

  // vectoring cordic: angle in q24 turns and floored magnitude
  task automatic cordic_polar(input int ya, input int xa, output logic [23:0] ang,
                              output int mag);
    longint x, y, dx, dy, m;
    logic [31:0] z;
    x = longint'(xa) * 64;
    y = longint'(ya) * 64;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < STEPS && i < 30; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x += dy; y -= dx; z += ATAN_Q32[i];
      end else begin
        x -= dy; y += dx; z -= ATAN_Q32[i];
      end
    end
    z = z + 32'd128;
    ang = z[31:8];
    m = (x * longint'(GAIN_INV_Q24)) >>> 30;
    if (m < 0) m = 0;
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    mag = int'(m);
  endtask

  // rotation cordic: cos and sin in q24, clamped to unity
  task automatic cordic_sincos(input logic [23:0] a, output int c, output int s);
    logic [31:0] z, t;
    bit neg;
    longint r, x, y, dx, dy, cv, sv;
    z = {a, 8'h00};
    t = z - 32'h40000000;
    neg = 0;
    if (t < 32'h80000000) begin
      z = z - 32'h80000000;
      neg = 1;
    end
    r = longint'(signed'(z));
    x = longint'(GAIN_INV_Q30);
    y = 0;
    for (int i = 0; i < STEPS && i < 30; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (r >= 0) begin
        x -= dy; y += dx; r -= ATAN_Q32[i];
      end else begin
        x += dy; y -= dx; r += ATAN_Q32[i];
      end
    end
    cv = (x + 32) >>> 6;
    sv = (y + 32) >>> 6;
    if (neg) begin
      cv = -cv;
      sv = -sv;
    end
    if (cv > 16777216) cv = 16777216;
    if (cv < -16777216) cv = -16777216;
    if (sv > 16777216) sv = 16777216;
    if (sv < -16777216) sv = -16777216;
    c = int'(cv);
    s = int'(sv);
  endtask

  // one observer step: updates predicted state, returns the estimate
  task automatic observe_sample(input sample_t smp, output estimate_t est);
    int udc, spd, inom, ts, base_v, inom_pk, rs_pu, ws, tf, den, ea, eb;
    int c, s, mag, ratio, ls, lsd, lsa, lsb, lm, fca, fcb, fa2, fb2;
    longint aw;
    logic [23:0] th, ang;
    udc = int'({1'b0, smp.udc});
    spd = smp.spd;
    inom = int'({1'b0, obs_reg[REG_NOMINAL_CURRENT]});
    ts = int'({1'b0, obs_reg[REG_SAMPLE_PERIOD]});
    base_v = fx_div(udc, K_SQRT3_Q20, 20);
    inom_pk = fx_mul(inom, K_SQRT2_Q20, 20);
    rs_pu = q20_to_q24(fx_div(fx_mul(inom_pk,
                int'({2'b0, obs_reg[REG_STATOR_RESISTANCE][30:1]}), 20), base_v, 20));
    // speed magnitude clamp, upper bound tested first
    aw = spd < 0 ? -longint'(spd) : longint'(spd);
    if (aw > longint'(obs_reg[REG_SPEED_MAX])) aw = obs_reg[REG_SPEED_MAX];
    else if (aw < longint'(obs_reg[REG_SPEED_MIN])) aw = obs_reg[REG_SPEED_MIN];
    ws = int'(aw);
    tf = fx_div(K_ONE_Q19, fx_mul(fx_mul(ws,
           int'({2'b0, obs_reg[REG_NOMINAL_FREQUENCY][30:1]}), 24), K_TWO_PI_Q24, 24), 24);
    // filter coefficients only follow a changed time constant
    if (tf != obs_last_tc) begin
      den = int'(longint'(tf) + ts);
      obs_coef_in = fx_div(ts, den, 24);
      obs_coef_fb = fx_div(tf, den, 24);
      obs_last_tc = tf;
    end
    if (smp.hold) begin
      obs_flux_a = 0;
      obs_flux_b = 0;
    end else begin
      ea = int'(longint'(smp.va) - fx_mul(smp.ia, rs_pu, 24));
      eb = int'(longint'(smp.vb) - fx_mul(smp.ib, rs_pu, 24));
      obs_flux_a = int'(longint'(fx_mul(fx_mul(ea, tf, 24), obs_coef_in, 24))
                        + fx_mul(obs_flux_a, obs_coef_fb, 24));
      obs_flux_b = int'(longint'(fx_mul(fx_mul(eb, tf, 24), obs_coef_in, 24))
                        + fx_mul(obs_flux_b, obs_coef_fb, 24));
    end
    // rotate the flux vector by seven eighths of a turn
    cordic_polar(obs_flux_b, obs_flux_a, th, mag);
    cordic_sincos(th + K_EIGHTH7_Q24, c, s);
    fca = fx_mul(c, mag, 24);
    fcb = fx_mul(s, mag, 24);
    // saliency flux at the previous angle
    ratio = fx_div(inom_pk, base_v, 20);
    ls = q20_to_q24(fx_mul(int'((longint'(obs_reg[REG_D_INDUCTANCE])
                                 + longint'(obs_reg[REG_Q_INDUCTANCE])) >>> 1), ratio, 20));
    lsd = q20_to_q24(fx_mul(int'((longint'(obs_reg[REG_D_INDUCTANCE])
                                  - longint'(obs_reg[REG_Q_INDUCTANCE])) >>> 1), ratio, 20));
    cordic_sincos({obs_angle[22:0], 1'b0}, c, s);
    lsa = int'(longint'(ls) + fx_mul(lsd, c, 24));
    lsb = int'(longint'(ls) - fx_mul(lsd, c, 24));
    lm = fx_mul(lsd, s, 24);
    fa2 = int'(longint'(fx_mul(smp.ia, lsa, 24)) + fx_mul(smp.ib, lm, 24));
    fb2 = int'(longint'(fx_mul(smp.ib, lsb, 24)) + fx_mul(smp.ia, lm, 24));
    if (smp.hold) obs_angle = 0;
    else begin
      cordic_polar(int'(longint'(fcb) - fb2), int'(longint'(fca) - fa2), ang, mag);
      obs_angle = ang;
    end
    est.ang = obs_angle;
    est.fca = fca;
    est.fcb = fcb;
    est.fa = fa2;
    est.fb = fb2;
    est.tc = tf;
  endtask

  // register write at the next edge, mirrored into the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    obs_reg[idx] = val;
  endtask

  task automatic write_all(input logic [30:0] vals [8]);
    for (int i = 0; i < 8; i++) write_reg(3'(i), vals[i]);
    @(posedge clk);
    cfg_write <= 0;
  endtask

  // offer one sample transaction and hold it until taken
  task automatic send_sample(input sample_t smp, input bit typed, input logic [23:0] t_ang);
    estimate_t est;
    sample_valid <= 1;
    volt_alpha <= smp.va;
    volt_beta <= smp.vb;
    curr_alpha <= smp.ia;
    curr_beta <= smp.ib;
    bus_voltage <= smp.udc;
    speed <= smp.spd;
    hold_reset <= smp.hold;
    do @(posedge clk); while (sample_stall);
    observe_sample(smp, est);
    if (typed) begin
      est.ang = t_ang;
      est.fca = 0;
      est.fcb = 0;
    end
    pending_estimates.push_back(est);
    samples_sent++;
    if (smp.hold) holds_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // random sample with mixed magnitudes so every bit toggles
  function automatic logic signed [31:0] rand_q24();
    return signed'($urandom) >>> $urandom_range(0, 10);
  endfunction

  task automatic run_random(input int n);
    sample_t smp;
    logic signed [31:0] run_speed;
    run_speed = rand_q24();
    for (int k = 0; k < n; k++) begin
      // speed held over runs so the coefficient update is skipped often
      if ($urandom_range(99) < 20) run_speed = rand_q24();
      smp.va = rand_q24();
      smp.vb = rand_q24();
      smp.ia = rand_q24();
      smp.ib = rand_q24();
      smp.udc = $urandom_range(99) < 5 ? 31'($urandom) : 31'($urandom >> $urandom_range(1, 12));
      smp.spd = $urandom_range(99) < 10 ? signed'($urandom) : run_speed;
      smp.hold = $urandom_range(99) < 5;
      send_sample(smp, 0, 0);
    end
    sample_valid <= 0;
  endtask

  task automatic wait_drained();
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic bit field_ok(string name, longint exp_v, longint got_v);
    if (exp_v == got_v) return 1;
    $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, got_v);
    return 0;
  endfunction

  // result side: random stall, compare each taken transaction
  always @(posedge clk) begin
    estimate_t e;
    bit ok;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        estimates_seen++;
        if (pending_estimates.size() == 0) begin
          $display("%0t unexpected result transaction angle %0d", $time, angle);
          errors++;
        end else begin
          e = pending_estimates.pop_front();
          ok = field_ok("angle", e.ang, angle);
          ok &= field_ok("flux_comp_alpha", e.fca, flux_comp_alpha);
          ok &= field_ok("flux_comp_beta", e.fcb, flux_comp_beta);
          ok &= field_ok("flux_curr_alpha", e.fa, flux_curr_alpha);
          ok &= field_ok("flux_curr_beta", e.fb, flux_curr_beta);
          ok &= field_ok("time_constant", e.tc, time_constant);
          if (!ok) errors++;
        end
      end
      result_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_estimates.size());
      $display("FAILURE");
      $finish;
    end
  end

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;
  localparam logic [30:0] UMAX = 31'h7fffffff;

  // directed rows: zero, extremes, hold, speed clamps, zero bus voltage
  row_t directed [] = '{
    '{'{0, 0, 0, 0, 31'd1048576, 0, 0}, 1, 24'd0},
    '{'{SMAX, SMAX, SMAX, SMAX, UMAX, SMAX, 1}, 1, 24'd0},
    '{'{SMAX, SMIN, 0, 0, 31'd1048576, 32'sd16777216, 0}, 0, 0},
    '{'{SMIN, SMAX, SMIN, SMAX, 31'd1, SMIN, 0}, 0, 0},
    '{'{SMIN, SMIN, SMIN, SMIN, UMAX, 0, 0}, 0, 0},
    '{'{32'sd16777216, 0, 32'sd1677721, 0, 31'd50000000, 32'sd8388608, 0}, 0, 0},
    '{'{0, 32'sd16777216, 0, -32'sd1677721, 31'd50000000, -32'sd8388608, 0}, 0, 0},
    '{'{-32'sd16777216, 0, 0, 0, 31'd0, 32'sd100, 0}, 0, 0},
    '{'{0, -32'sd16777216, 32'sd4096, 32'sd4096, 31'd0, 32'sd33554432, 0}, 0, 0},
    '{'{32'sd5000000, 32'sd5000000, 32'sd100000, 32'sd100000, 31'd400000000,
        -32'sd33554432, 0}, 0, 0},
    '{'{SMIN, SMIN, SMIN, SMIN, 31'd0, SMIN, 1}, 1, 24'd0},
    '{'{32'sd5000000, -32'sd5000000, 0, 0, 31'd400000000, 32'sd167772, 0}, 0, 0},
    '{'{-1, -1, -1, -1, 31'd1, -1, 0}, 0, 0},
    '{'{1, 1, 1, 1, 31'd1, 1, 0}, 0, 0}
  };

  logic [30:0] setting [8];

  initial begin
    obs_reg[REG_STATOR_RESISTANCE] = 0;
    obs_reg[REG_D_INDUCTANCE] = 0;
    obs_reg[REG_Q_INDUCTANCE] = 0;
    obs_reg[REG_NOMINAL_CURRENT] = RST_NOMINAL_CURRENT;
    obs_reg[REG_NOMINAL_FREQUENCY] = RST_NOMINAL_FREQUENCY;
    obs_reg[REG_SPEED_MAX] = RST_SPEED_MAX;
    obs_reg[REG_SPEED_MIN] = RST_SPEED_MIN;
    obs_reg[REG_SAMPLE_PERIOD] = RST_SAMPLE_PERIOD;
    obs_flux_a = 0; obs_flux_b = 0; obs_last_tc = 0;
    obs_coef_in = 0; obs_coef_fb = 0; obs_angle = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // phase 0: reset settings, no idling
    foreach (directed[i]) send_sample(directed[i].s, directed[i].typed, directed[i].ang);
    run_random(PHASE_ITEMS - directed.size());
    wait_drained();

    // phase 1: plausible machine, sender idles
    setting = '{31'($urandom_range(1 << 22)), 31'($urandom_range(1 << 18)),
                31'($urandom_range(1 << 18)), 31'($urandom_range(1 << 20, 1 << 24)),
                31'd838860800, 31'd33554432, 31'd167772, 31'($urandom_range(500, 5000))};
    write_all(setting);
    send_idle_pct = 62;
    run_random(PHASE_ITEMS);
    wait_drained();

    // phase 2: every register but q inductance and minimum speed at its maximum, result side stalls
    setting = '{UMAX, UMAX, 31'd0, UMAX, UMAX, UMAX, 31'd1, UMAX};
    write_all(setting);
    send_idle_pct = 0;
    recv_stall_pct = 62;
    run_random(PHASE_ITEMS / 2);
    wait_drained();
    // inverted clamp, zero divisors, zero sample period
    setting = '{31'd0, 31'd0, UMAX, 31'd0, 31'd0, 31'd1, UMAX, 31'd0};
    write_all(setting);
    run_random(PHASE_ITEMS / 2);
    wait_drained();

    // phase 3: random settings, both sides idle
    for (int i = 0; i < 8; i++) setting[i] = 31'($urandom >> $urandom_range(1, 10));
    write_all(setting);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    run_random(PHASE_ITEMS);
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("observer run: %0d samples (%0d holds) over five register settings and four idle mixes",
             samples_sent, holds_sent);
    $display("%0d estimates checked, %0d mismatching transactions", estimates_seen, errors);
    if (errors == 0 && pending_estimates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
